>>> hw/rtl/fat32_deleted_entry_scanner_unit_macros.svh
// Assertion macros shared by the deleted-entry scanner RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef FAT32_DELETED_ENTRY_SCANNER_UNIT_MACROS_SVH
`define FAT32_DELETED_ENTRY_SCANNER_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define FDES_ASSERT_IMPLY(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FDES_ASSERT_NEXT(label, clk, rst, cond, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error(msg);

`endif

>>> hw/rtl/fdes_pkg.sv
// Types, codes and constants of the deleted-entry scanner.
// Depends on nothing; imported by every scanner module but fdes_ram.
package fdes_pkg;

   localparam int TABLE_ENTRIES_DEFAULT = 64;
   localparam int QUEUE_DEPTH_DEFAULT   = 2;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CLUSTERS_W = 28;
   localparam logic [CLUSTERS_W-1:0] DATA_CLUSTERS_RESET = 28'd65536;
   localparam logic [0:0] REG_DATA_CLUSTERS = 1'b0;

   // Table row: cluster and the low 27 bits of a size that is at most 64 MiB.
   localparam int SIZE_KEEP_W = 27;
   localparam int ROW_W       = 32 + SIZE_KEEP_W;
   localparam logic [31:0] MAX_DELETED_SIZE = 32'h0400_0000;

   localparam logic [7:0] MARK_DELETED = 8'hE5;
   localparam logic [7:0] MARK_END     = 8'h00;
   localparam logic [7:0] MARK_DOT     = 8'h2E;
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] ATTR_LFN     = 8'h0F;
   localparam int ATTR_VOLUME_BIT = 3;
   localparam int ATTR_DIR_BIT    = 4;
   localparam logic [4:0] POS_LAST = 5'd31;

   localparam logic [1:0] KIND_IGNORED = 2'd0;
   localparam logic [1:0] KIND_CAND    = 2'd1;
   localparam logic [1:0] KIND_SUBDIR  = 2'd2;
   localparam logic [1:0] KIND_END     = 2'd3;

   typedef enum logic [1:0] {
      JOB_END,
      JOB_IGNORE,
      JOB_CAND,
      JOB_SUBDIR
   } job_kind_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_CHECK,
      B_SEARCH,
      B_INSERT,
      B_EMIT
   } back_state_type;

   typedef struct packed {
      logic [7:0] entry_byte;
      logic       dir_start;
      logic       scan_start;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  entry_kind;
      logic [31:0] start_cluster;
      logic [31:0] file_bytes;
      logic [23:0] ext_chars;
      logic [1:0]  ext_length;
      logic [6:0]  candidate_number;
   } rsp_payload_type;

   typedef struct packed {
      job_kind_type kind;
      logic         clear;
      logic [31:0]  cluster;
      logic [31:0]  size;
      logic [23:0]  ext;
      logic [1:0]   elen;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

>>> hw/rtl/fdes_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module fdes_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/fdes_front.sv
// Front end: takes directory bytes, assembles 32-byte entries and classifies them.
// Depends on fdes_pkg; feeds fdes_queue.
module fdes_front import fdes_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_payload_type req_payload,
   input  q_status_type    q_status,
   output logic            push,
   output job_type         push_job
);

   logic [4:0] pos_ff, pos_in, pos_eff;
   logic       ended_ff, ended_in, ended_eff;
   logic       pend_clear_ff, pend_clear_in, clear_eff;
   logic [7:0] entry_ff [0:30];
   logic       accept, restart;
   logic [7:0] b, attr, first;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      b         = req_payload.entry_byte;
      restart   = req_payload.dir_start || req_payload.scan_start;
      pos_eff   = restart ? 5'd0 : pos_ff;
      ended_eff = restart ? 1'b0 : ended_ff;
      clear_eff = pend_clear_ff || req_payload.scan_start;
      attr      = entry_ff[11];
      first     = entry_ff[0];

      push_job.clear   = clear_eff;
      push_job.cluster = {entry_ff[21], entry_ff[20], entry_ff[27], entry_ff[26]};
      push_job.size    = {b, entry_ff[30], entry_ff[29], entry_ff[28]};
      push_job.ext     = {entry_ff[10], entry_ff[9], entry_ff[8]};
      if (entry_ff[8] == CHAR_SPACE) begin
         push_job.elen = 2'd0;
      end else if (entry_ff[9] == CHAR_SPACE) begin
         push_job.elen = 2'd1;
      end else if (entry_ff[10] == CHAR_SPACE) begin
         push_job.elen = 2'd2;
      end else begin
         push_job.elen = 2'd3;
      end

      // Long-name and volume entries fall through to the ignore code.
      if (attr == ATTR_LFN || attr[ATTR_VOLUME_BIT]) begin
         push_job.kind = JOB_IGNORE;
      end else if (first == MARK_DELETED && !attr[ATTR_DIR_BIT]) begin
         push_job.kind = JOB_CAND;
      end else if (first != MARK_DELETED && attr[ATTR_DIR_BIT] && first != MARK_DOT
                   && push_job.cluster >= 32'd2) begin
         push_job.kind = JOB_SUBDIR;
      end else begin
         push_job.kind = JOB_IGNORE;
      end

      push          = 1'b0;
      pos_in        = pos_ff;
      ended_in      = ended_ff;
      pend_clear_in = pend_clear_ff;
      if (accept) begin
         pos_in        = pos_eff + 5'd1;
         ended_in      = ended_eff;
         pend_clear_in = clear_eff;
         if (!ended_eff) begin
            if (pos_eff == 5'd0 && b == MARK_END) begin
               push          = 1'b1;
               push_job.kind = JOB_END;
               ended_in      = 1'b1;
            end else if (pos_eff == POS_LAST) begin
               push = 1'b1;
            end
         end
         if (push) begin
            pend_clear_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff        <= 5'd0;
         ended_ff      <= 1'b0;
         pend_clear_ff <= 1'b0;
      end else begin
         pos_ff        <= pos_in;
         ended_ff      <= ended_in;
         pend_clear_ff <= pend_clear_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && pos_eff != POS_LAST) begin
         entry_ff[pos_eff] <= b;
      end
   end

endmodule

>>> hw/rtl/fdes_queue.sv
// Short first-word-fall-through queue of classified entries.
// Depends on fdes_pkg; sits between fdes_front and fdes_back.
module fdes_queue import fdes_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH_DEFAULT,
   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CW = $clog2(DEPTH + 1)
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      push_job,
   input  logic         pop,
   output job_type      head_job,
   output q_status_type status
);

   job_type       slot_ff [0:DEPTH-1];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic          do_push, do_pop;

   always_comb begin
      status.full  = (count_ff == CW'(DEPTH));
      status.empty = (count_ff == '0);
      do_push      = push && !status.full;
      do_pop       = pop && !status.empty;
      head_job     = slot_ff[rd_ptr_ff];
      wr_ptr_in    = wr_ptr_ff;
      rd_ptr_in    = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(do_push) - CW'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

>>> hw/rtl/fdes_back.sv
// Back end: checks candidates, searches and fills the table, drives result beats.
// Depends on fdes_pkg, fdes_ram and the macros header; drains fdes_queue.
`include "fat32_deleted_entry_scanner_unit_macros.svh"
module fdes_back import fdes_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
   localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1,
   localparam int CNT_W = $clog2(TABLE_ENTRIES + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [CLUSTERS_W-1:0] data_clusters,
   input  q_status_type          q_status,
   input  job_type               head_job,
   output logic                  pop,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload
);

   back_state_type  state_ff, state_in;
   job_type         job_ff, job_in;
   logic [CNT_W-1:0] count_ff, count_in, issue_ff, issue_in;
   logic            cmp_valid_ff, cmp_valid_in;
   logic [1:0]      kind_ff, kind_in;
   logic [6:0]      num_ff, num_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic            ram_wr_en, ram_rd_en;
   logic [ROW_W-1:0] ram_rd_data, row_key;
   logic            ok, match, slot_free;

   always_comb begin
      row_key   = {job_ff.cluster, job_ff.size[SIZE_KEEP_W-1:0]};
      ok        = job_ff.kind == JOB_CAND && job_ff.size != 32'd0
                  && job_ff.size <= MAX_DELETED_SIZE && job_ff.cluster >= 32'd2
                  && {1'b0, job_ff.cluster} < ({5'd0, data_clusters} + 33'd2)
                  && count_ff < CNT_W'(TABLE_ENTRIES);
      match     = cmp_valid_ff && ram_rd_data == row_key;
      slot_free = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) state_in = B_CHECK;
         end
         B_CHECK: begin
            if (ok) begin
               state_in = (count_ff == '0) ? B_INSERT : B_SEARCH;
            end else begin
               state_in = B_EMIT;
            end
         end
         B_SEARCH: begin
            if (match) begin
               state_in = B_EMIT;
            end else if (issue_ff == count_ff && !cmp_valid_ff) begin
               state_in = B_INSERT;
            end
         end
         B_INSERT: state_in = B_EMIT;
         B_EMIT: begin
            if (slot_free) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      pop          = 1'b0;
      job_in       = job_ff;
      count_in     = count_ff;
      issue_in     = issue_ff;
      cmp_valid_in = 1'b0;
      kind_in      = kind_ff;
      num_in       = num_ff;
      ram_wr_en    = 1'b0;
      ram_rd_en    = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_in       = rsp_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_status.empty) begin
               pop    = 1'b1;
               job_in = head_job;
               if (head_job.clear) count_in = '0;
            end
         end
         B_CHECK: begin
            issue_in = '0;
            num_in   = 7'd0;
            unique case (job_ff.kind)
               JOB_END:    kind_in = KIND_END;
               JOB_SUBDIR: kind_in = KIND_SUBDIR;
               JOB_CAND,
               JOB_IGNORE: kind_in = KIND_IGNORED;
               default:    kind_in = KIND_IGNORED;
            endcase
         end
         B_SEARCH: begin
            // One row read per cycle; the compare uses the registered read data in the next cycle.
            if (issue_ff != count_ff && !match) begin
               ram_rd_en    = 1'b1;
               issue_in     = issue_ff + 1'b1;
               cmp_valid_in = 1'b1;
            end
         end
         B_INSERT: begin
            ram_wr_en = 1'b1;
            count_in  = count_ff + 1'b1;
            kind_in   = KIND_CAND;
            num_in    = 7'(count_ff + 1'b1);
         end
         B_EMIT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               if (job_ff.kind == JOB_END) begin
                  rsp_in            = '0;
                  rsp_in.entry_kind = KIND_END;
               end else begin
                  rsp_in.entry_kind       = kind_ff;
                  rsp_in.start_cluster    = job_ff.cluster;
                  rsp_in.file_bytes       = job_ff.size;
                  rsp_in.ext_chars        = job_ff.ext;
                  rsp_in.ext_length       = job_ff.elen;
                  rsp_in.candidate_number = num_ff;
               end
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         count_ff     <= '0;
         issue_ff     <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         issue_ff     <= issue_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff  <= job_in;
      kind_ff <= kind_in;
      num_ff  <= num_in;
      rsp_ff  <= rsp_in;
   end

   fdes_ram #(
      .WIDTH (ROW_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (row_key),
      .rd_en   (ram_rd_en),
      .rd_addr (issue_ff[AW-1:0]),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   `FDES_ASSERT_IMPLY(a_insert_has_room, clock, reset, ram_wr_en, count_ff < CNT_W'(TABLE_ENTRIES), "table write with no free row")
   `FDES_ASSERT_IMPLY(a_search_is_cand, clock, reset, state_ff == B_SEARCH, job_ff.kind == JOB_CAND, "search started for a non-candidate entry")
   `FDES_ASSERT_NEXT(a_insert_reports, clock, reset, state_ff == B_INSERT, state_ff == B_EMIT && kind_ff == KIND_CAND && num_ff != 7'd0, "inserted candidate not reported with a number")

endmodule

>>> hw/rtl/fat32_deleted_entry_scanner_unit.sv
// Top level of the FAT32 deleted-entry scanner: register port and the
// front end, entry queue and back end. Depends on fdes_pkg and all fdes_* modules.
//
//   Channel   Direction  Handshake              Beat carries
//   req_      in         req_valid/req_ready    one directory byte plus start flags
//   rsp_      out        rsp_valid/rsp_ready    one classified entry result
//   csr_      in/out     APB psel/penable       data_clusters register
//
// Cycles: the front end takes one byte per cycle while the entry queue has room.
// The back end takes each entry through its idle, check and emit states, adding an insert
// state for a candidate that it records and, when the table holds rows, a duplicate search
// through the table RAM's single read port.
// Reset is synchronous and clears control state; the table needs no clearing pass.
// A stalled result beat holds in the output register; the back end carries on with the
// next entry up to its emit state, and the front end keeps working until the queue fills.
module fat32_deleted_entry_scanner_unit import fdes_pkg::*; #(
   parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEFAULT,
   parameter int QUEUE_DEPTH   = QUEUE_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   // Byte input channel.
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_payload_type       req_payload,
   // Result channel.
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_payload_type       rsp_payload,
   // Configuration port.
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [CLUSTERS_W-1:0] data_clusters_ff, data_clusters_in;
   logic                  csr_write;
   logic                  push, pop;
   job_type               push_job, head_job;
   q_status_type          q_status;

   // The register sits at byte address zero; the word index is paddr bit 2.
   always_comb begin
      csr_write        = csr_psel && csr_penable && csr_pwrite && csr_pready;
      data_clusters_in = data_clusters_ff;
      if (csr_write && csr_paddr[2:2] == REG_DATA_CLUSTERS) begin
         data_clusters_in = csr_pwdata[CLUSTERS_W-1:0];
      end
      if (csr_paddr[2:2] == REG_DATA_CLUSTERS) begin
         csr_prdata = {{(CSR_DATA_W - CLUSTERS_W){1'b0}}, data_clusters_ff};
      end else begin
         csr_prdata = '0;
      end
   end

   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         data_clusters_ff <= DATA_CLUSTERS_RESET;
      end else begin
         data_clusters_ff <= data_clusters_in;
      end
   end

   // Byte assembly and classification.
   fdes_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_status    (q_status),
      .push        (push),
      .push_job    (push_job)
   );

   // Entries in flight between the two halves.
   fdes_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (q_status)
   );

   // Candidate checks, table search and result beats.
   fdes_back #(
      .TABLE_ENTRIES (TABLE_ENTRIES)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .data_clusters (data_clusters_ff),
      .q_status      (q_status),
      .head_job      (head_job),
      .pop           (pop),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_payload   (rsp_payload)
   );

endmodule

>>> tb/tb.sv
// Self-checking testbench for fat32_deleted_entry_scanner_unit: streams directory bytes,
// predicts every classified entry in-house and checks each result beat field by field.
// Depends on fdes_pkg and the scanner RTL.
`timescale 1ns / 1ps

module tb;
   import fdes_pkg::*;

   localparam int TABLE_SLOTS    = TABLE_ENTRIES_DEFAULT;
   localparam int STALL_LIMIT    = 5000;
   localparam int LONG_HOLD      = 400;
   localparam int SETTLE_CYCLES  = 150;
   localparam int RANDOM_BYTES   = 850;
   localparam logic [CSR_ADDR_W-1:0] ADDR_DATA_CLUSTERS = CSR_ADDR_W'(4 * REG_DATA_CLUSTERS);
   localparam logic [7:0] ATTR_ARCHIVE = 8'h20;
   localparam logic [7:0] ATTR_DIR     = 8'(1 << ATTR_DIR_BIT);
   localparam logic [7:0] ATTR_VOL     = 8'(1 << ATTR_VOLUME_BIT);

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_ready;
   req_payload_type       req_payload = '0;
   logic                  rsp_valid;
   logic                  rsp_ready   = 1'b0;
   rsp_payload_type       rsp_payload;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Run control shared by the stimulus, the receiver and the checker.
   bit quiet           = 1'b0;
   int hold_requests   = 0;
   int error_count     = 0;
   int predicted_total = 0;
   int accepted_bytes  = 0;
   int idle_cycles     = 0;

   // Shadow of the scanner state, advanced once per accepted byte beat.
   logic [CLUSTERS_W-1:0] clusters_cfg = DATA_CLUSTERS_RESET;
   logic [4:0]            scan_pos     = '0;
   logic [7:0]            entry_shadow [32];
   bit                    dir_closed   = 1'b0;
   int                    found_count  = 0;
   logic [31:0]           found_cluster [TABLE_SLOTS];
   logic [31:0]           found_size [TABLE_SLOTS];
   rsp_payload_type       pending_results [$];

   // Entry image under construction by the stimulus.
   logic [7:0] entry_img [32];

   fat32_deleted_entry_scanner_unit u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial forever #5 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------------------

   // Classifies the 32 collected bytes and records a new deleted-file candidate.
   function automatic rsp_payload_type classify_entry();
      rsp_payload_type r;
      logic [7:0]      attr;
      logic [31:0]     cl;
      logic [31:0]     sz;
      bit              deleted;
      bit              fits;
      bit              dup;
      int              elen;
      attr    = entry_shadow[11];
      cl      = {entry_shadow[21], entry_shadow[20], entry_shadow[27], entry_shadow[26]};
      sz      = {entry_shadow[31], entry_shadow[30], entry_shadow[29], entry_shadow[28]};
      deleted = (entry_shadow[0] == MARK_DELETED);
      // Extension length counts characters up to the first space.
      elen = 0;
      for (int i = 0; i < 3; i++)
         if (elen == i && entry_shadow[8 + i] != CHAR_SPACE) elen++;
      r.entry_kind       = KIND_IGNORED;
      r.start_cluster    = cl;
      r.file_bytes       = sz;
      r.ext_chars        = {entry_shadow[10], entry_shadow[9], entry_shadow[8]};
      r.ext_length       = elen[1:0];
      r.candidate_number = '0;
      if (attr == ATTR_LFN || attr[ATTR_VOLUME_BIT]) begin
         // Long-name and volume-label entries are never reported.
      end else if (deleted && !attr[ATTR_DIR_BIT]) begin
         fits = sz != 0 && sz <= MAX_DELETED_SIZE && cl >= 2
                && {1'b0, cl} < {5'b0, clusters_cfg} + 33'd2 && found_count < TABLE_SLOTS;
         dup = 1'b0;
         for (int i = 0; i < found_count; i++)
            if (found_cluster[i] == cl && found_size[i] == sz) dup = 1'b1;
         if (fits && !dup) begin
            found_cluster[found_count] = cl;
            found_size[found_count]    = sz;
            found_count++;
            r.entry_kind       = KIND_CAND;
            r.candidate_number = 7'(found_count);
         end
      end else if (!deleted && attr[ATTR_DIR_BIT] && entry_shadow[0] != MARK_DOT && cl >= 2) begin
         // Subdirectories are not range checked against the cluster count.
         r.entry_kind = KIND_SUBDIR;
      end
      return r;
   endfunction

   // Advances the shadow state by one accepted byte and queues any result it causes.
   function automatic void predict_byte(input req_payload_type p);
      rsp_payload_type r;
      logic [4:0]      slot;
      accepted_bytes++;
      if (p.scan_start) found_count = 0;
      if (p.scan_start || p.dir_start) begin
         dir_closed = 1'b0;
         scan_pos   = '0;
      end
      slot               = scan_pos;
      entry_shadow[slot] = p.entry_byte;
      if (!dir_closed) begin
         if (slot == 0 && p.entry_byte == MARK_END) begin
            // End mark reports at once with every other field zero.
            dir_closed   = 1'b1;
            r            = '0;
            r.entry_kind = KIND_END;
            pending_results = {pending_results, r};
            predicted_total++;
         end else if (slot == POS_LAST) begin
            r               = classify_entry();
            pending_results = {pending_results, r};
            predicted_total++;
         end
      end
      // Bytes keep counting after the end mark so alignment is held.
      scan_pos = slot + 5'd1;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------------------

   // Offers one byte beat, with an optional idle burst first, and predicts it on acceptance.
   task automatic send_byte(input logic [7:0] value, input bit dstart, input bit sstart);
      int gap;
      gap = 0;
      if (!quiet && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{entry_byte: value, dir_start: dstart, scan_start: sstart};
      do @(posedge clock); while (!(req_valid && req_ready));
      predict_byte(req_payload);
   endtask

   // Sends the first count bytes of the entry image; the start flags ride on byte 0.
   task automatic send_entry(input bit dstart, input bit sstart, input int count);
      for (int i = 0; i < count; i++)
         send_byte(entry_img[i], dstart && i == 0, sstart && i == 0);
   endtask

   function automatic logic [23:0] ext3(input logic [7:0] c0, c1, c2);
      return {c2, c1, c0};
   endfunction

   // Fills the entry image: random name and padding bytes, chosen key fields.
   function automatic void build_entry(input logic [7:0] first, input logic [7:0] attr,
                                       input logic [31:0] cl, input logic [31:0] sz,
                                       input logic [23:0] ext);
      for (int i = 0; i < 32; i++) entry_img[i] = 8'($urandom);
      for (int i = 1; i < 8; i++) entry_img[i] = 8'($urandom_range(65, 90));
      entry_img[0]  = first;
      entry_img[11] = attr;
      {entry_img[10], entry_img[9], entry_img[8]} = ext;
      {entry_img[21], entry_img[20], entry_img[27], entry_img[26]} = cl;
      {entry_img[31], entry_img[30], entry_img[29], entry_img[28]} = sz;
   endfunction

   task automatic put_entry(input logic [7:0] first, input logic [7:0] attr,
                            input logic [31:0] cl, input logic [31:0] sz,
                            input logic [23:0] ext, input bit dstart, input bit sstart);
      build_entry(first, attr, cl, sz, ext);
      send_entry(dstart, sstart, 32);
   endtask

   // Releases the byte channel and waits until every predicted result has arrived,
   // then lets the back end settle.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB transfer to the cluster count register; a read is checked against the shadow.
   task automatic csr_access(input bit write, input logic [CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= ADDR_DATA_CLUSTERS;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (write) begin
         clusters_cfg = data[CLUSTERS_W-1:0];
      end else if (csr_prdata[CLUSTERS_W-1:0] !== clusters_cfg) begin
         $error("data_clusters: expected 0x%0h, got 0x%0h", clusters_cfg,
                csr_prdata[CLUSTERS_W-1:0]);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_clusters(input logic [31:0] value);
      wait_drained();
      csr_access(1'b1, value);
      csr_access(1'b0, '0);
   endtask

   // ---------------------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------------------

   task automatic test_register_readback();
      csr_access(1'b0, '0);
      set_clusters(32'hFFFF_FFFF);
      set_clusters(32'h0);
      set_clusters(32'(DATA_CLUSTERS_RESET));
   endtask

   task automatic test_directed_entries();
      logic [31:0] top;
      logic [23:0] txt;
      top = {4'b0, clusters_cfg} + 32'd1;
      txt = ext3("T", "X", "T");
      put_entry(MARK_DELETED, ATTR_ARCHIVE, 32'd2, 32'd1, txt, 1'b1, 1'b1);
      // Same cluster and size again is a duplicate; a new size is a new candidate.
      put_entry(MARK_DELETED, ATTR_ARCHIVE, 32'd2, 32'd1, txt, 1'b0, 1'b0);
      put_entry(MARK_DELETED, 8'h00, 32'd2, 32'd2, txt, 1'b0, 1'b0);
      put_entry(MARK_DELETED, ATTR_ARCHIVE, 32'd3, 32'd0, txt, 1'b0, 1'b0);
      put_entry(MARK_DELETED, ATTR_ARCHIVE, top, MAX_DELETED_SIZE, txt, 1'b0, 1'b0);
      put_entry(MARK_DELETED, ATTR_ARCHIVE, 32'd5, MAX_DELETED_SIZE + 1, txt, 1'b0, 1'b0);
      put_entry(MARK_DELETED, ATTR_ARCHIVE, 32'd1, 32'd10, txt, 1'b0, 1'b0);
      put_entry(MARK_DELETED, ATTR_ARCHIVE, top + 1, 32'd10, txt, 1'b0, 1'b0);
      put_entry(MARK_DELETED, ATTR_LFN, 32'd6, 32'd10, txt, 1'b0, 1'b0);
      put_entry(MARK_DELETED, ATTR_VOL, 32'd7, 32'd10, txt, 1'b0, 1'b0);
      put_entry(MARK_DELETED, ATTR_DIR, 32'd8, 32'd10, txt, 1'b0, 1'b0);
      // Live directories: normal, dot entry, bad cluster, cluster beyond the volume.
      put_entry("D", ATTR_DIR, 32'd100, 32'd0, ext3(" ", " ", " "), 1'b0, 1'b0);
      put_entry(MARK_DOT, ATTR_DIR, 32'd100, 32'd0, ext3(" ", " ", " "), 1'b0, 1'b0);
      put_entry("E", ATTR_DIR, 32'd1, 32'd0, txt, 1'b0, 1'b0);
      put_entry("F", ATTR_DIR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, txt, 1'b0, 1'b0);
      put_entry("G", ATTR_ARCHIVE, 32'd9, 32'd20, ext3("A", " ", "B"), 1'b0, 1'b0);
      put_entry(8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 24'hFF_FFFF, 1'b0, 1'b0);
      put_entry(MARK_DELETED, ATTR_ARCHIVE, 32'h0000_FFFF, 32'd300, ext3("J", "P", " "),
                1'b0, 1'b0);
      // End mark, then entries that must stay silent until the next directory start.
      put_entry(MARK_END, ATTR_ARCHIVE, 32'd11, 32'd12, txt, 1'b0, 1'b0);
      put_entry(MARK_DELETED, ATTR_ARCHIVE, 32'd11, 32'd12, txt, 1'b0, 1'b0);
      put_entry(MARK_END, ATTR_ARCHIVE, 32'd11, 32'd12, txt, 1'b0, 1'b0);
      put_entry("H", ATTR_DIR, 32'd200, 32'd0, txt, 1'b1, 1'b0);
      put_entry(MARK_END, ATTR_ARCHIVE, 32'd13, 32'd14, txt, 1'b1, 1'b0);
      // A scan start empties the table, so the first file is new again.
      put_entry(MARK_DELETED, ATTR_ARCHIVE, 32'd2, 32'd1, txt, 1'b0, 1'b1);
   endtask

   task automatic test_table_fill();
      for (int i = 0; i < TABLE_SLOTS + 2; i++)
         put_entry(MARK_DELETED, ATTR_ARCHIVE, 32'(i + 2), 32'(1000 + i),
                   ext3("D", "A", "T"), 1'b0, i == 0);
      put_entry(MARK_DELETED, ATTR_ARCHIVE, 32'd2, 32'd1000, ext3("D", "A", "T"), 1'b0, 1'b0);
      put_entry("S", ATTR_DIR, 32'd77, 32'd0, ext3(" ", " ", " "), 1'b0, 1'b0);
   endtask

   // The receiver holds off for a long stretch while bytes keep coming, so the entry
   // queue fills and the byte channel must stall.
   task automatic test_backpressure();
      quiet = 1'b1;
      hold_requests++;
      for (int i = 0; i < 8; i++) begin
         if (i % 2 == 0)
            put_entry(MARK_DELETED, ATTR_ARCHIVE, 32'(i + 40), 32'(i + 1),
                      ext3("B", "I", "N"), 1'b0, i == 0);
         else
            put_entry("P", ATTR_DIR, 32'(i + 40), 32'd0, ext3(" ", " ", " "), 1'b0, 1'b0);
      end
      quiet = 1'b0;
   endtask

   // Cluster range edges for the extreme register values; the last value carries
   // upper bits that the register must drop.
   task automatic test_cluster_limits();
      logic [31:0] limits [4];
      logic [31:0] top;
      limits = '{32'h0, 32'h1, 32'h0FFF_FFFF, {4'hF, 28'($urandom)}};
      foreach (limits[k]) begin
         set_clusters(limits[k]);
         top = {4'b0, clusters_cfg} + 32'd1;
         put_entry(MARK_DELETED, ATTR_ARCHIVE, 32'd1, 32'd7, ext3("L", "O", "W"), 1'b1, 1'b1);
         put_entry(MARK_DELETED, ATTR_ARCHIVE, 32'd2, 32'd7, ext3("L", "O", "W"), 1'b0, 1'b0);
         put_entry(MARK_DELETED, ATTR_ARCHIVE, top, 32'd8, ext3("T", "O", "P"), 1'b0, 1'b0);
         put_entry(MARK_DELETED, ATTR_ARCHIVE, top + 1, 32'd9, ext3("T", "O", "P"),
                   1'b0, 1'b0);
         put_entry("X", ATTR_DIR, top + 1, 32'd0, ext3(" ", " ", " "), 1'b0, 1'b0);
      end
   endtask

   // Mostly well-formed entries with random content, plus noise bytes and cut-off entries
   // that force a realigning directory start.
   task automatic test_random_traffic();
      int          dc;
      int          pick;
      int          idx;
      int          bytes_base;
      bit          realign;
      bit          reuse;
      logic [7:0]  first;
      logic [7:0]  attr;
      logic [31:0] cl;
      logic [31:0] sz;
      logic [23:0] ext;
      dc = $urandom_range(16, 4000);
      set_clusters(32'(dc));
      bytes_base   = accepted_bytes;
      realign      = 1'b1;
      while (accepted_bytes - bytes_base < RANDOM_BYTES) begin
         // The tail of the run goes without idling on either side.
         if (accepted_bytes - bytes_base > RANDOM_BYTES * 3 / 4) quiet = 1'b1;
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            repeat ($urandom_range(1, 40))
               send_byte(8'($urandom), $urandom_range(0, 15) == 0, $urandom_range(0, 31) == 0);
            realign = 1'b1;
         end else begin
            pick = $urandom_range(0, 99);
            if (pick < 55) first = MARK_DELETED;
            else if (pick < 60) first = MARK_END;
            else if (pick < 65) first = MARK_DOT;
            else if (pick < 85) first = 8'($urandom_range(65, 90));
            else first = 8'($urandom);
            pick = $urandom_range(0, 99);
            if (pick < 45) attr = ATTR_ARCHIVE;
            else if (pick < 55) attr = 8'h00;
            else if (pick < 70) attr = ATTR_DIR;
            else if (pick < 78) attr = ATTR_LFN;
            else if (pick < 85) attr = ATTR_VOL | 8'($urandom);
            else attr = 8'($urandom);
            reuse = 1'b0;
            pick  = $urandom_range(0, 99);
            if (pick < 60) begin
               cl = $urandom_range(0, dc + 3);
            end else if (pick < 80 && found_count > 0) begin
               idx   = $urandom_range(0, found_count - 1);
               cl    = found_cluster[idx];
               sz    = found_size[idx];
               reuse = 1'b1;
            end else begin
               cl = $urandom;
            end
            if (!reuse) begin
               pick = $urandom_range(0, 99);
               if (pick < 70) sz = $urandom_range(1, int'(MAX_DELETED_SIZE));
               else if (pick < 80) sz = '0;
               else if (pick < 88) sz = MAX_DELETED_SIZE;
               else sz = $urandom;
            end
            for (int i = 0; i < 3; i++) begin
               pick = $urandom_range(0, 3);
               ext[8*i +: 8] = pick == 0 ? CHAR_SPACE
                             : (pick == 3 ? 8'($urandom) : 8'($urandom_range(65, 90)));
            end
            build_entry(first, attr, cl, sz, ext);
            pick = $urandom_range(0, 99);
            send_entry(realign || $urandom_range(0, 7) == 0, $urandom_range(0, 19) == 0,
                       pick < 8 ? $urandom_range(1, 31) : 32);
            realign = pick < 8;
         end
      end
   endtask

   // ---------------------------------------------------------------------------------------
   // Receiver, checker and watchdog
   // ---------------------------------------------------------------------------------------

   // Random stall bursts, plus the long hold-off that the backpressure test asks for.
   initial begin : rsp_side
      int stall_left;
      int served;
      stall_left = 0;
      served     = 0;
      forever begin
         @(posedge clock);
         if (served != hold_requests) begin
            served     = hold_requests;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && !quiet && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 10);
         end
         if (stall_left > 0) begin
            rsp_ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Each result beat is matched against the oldest prediction.
   always @(posedge clock) begin : rsp_check
      rsp_payload_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("entry_kind: expected no beat, got 0x%0h", rsp_payload.entry_kind);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_payload.entry_kind !== want.entry_kind) begin
               $error("entry_kind: expected 0x%0h, got 0x%0h", want.entry_kind,
                      rsp_payload.entry_kind);
               error_count++;
            end
            if (rsp_payload.start_cluster !== want.start_cluster) begin
               $error("start_cluster: expected 0x%0h, got 0x%0h", want.start_cluster,
                      rsp_payload.start_cluster);
               error_count++;
            end
            if (rsp_payload.file_bytes !== want.file_bytes) begin
               $error("file_bytes: expected 0x%0h, got 0x%0h", want.file_bytes,
                      rsp_payload.file_bytes);
               error_count++;
            end
            if (rsp_payload.ext_chars !== want.ext_chars) begin
               $error("ext_chars: expected 0x%0h, got 0x%0h", want.ext_chars,
                      rsp_payload.ext_chars);
               error_count++;
            end
            if (rsp_payload.ext_length !== want.ext_length) begin
               $error("ext_length: expected 0x%0h, got 0x%0h", want.ext_length,
                      rsp_payload.ext_length);
               error_count++;
            end
            if (rsp_payload.candidate_number !== want.candidate_number) begin
               $error("candidate_number: expected 0x%0h, got 0x%0h", want.candidate_number,
                      rsp_payload.candidate_number);
               error_count++;
            end
         end
      end
   end

   // Ends the run when no beat or register access has gone through for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_register_readback();
      test_directed_entries();
      test_table_fill();
      test_backpressure();
      test_cluster_limits();
      test_random_traffic();
      wait_drained();
      if (error_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
